// ----- sv/mi4_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package mi4_pkg;
	localparam int ElementBits  = 32;
	localparam int FractionBits = 16;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_RA,
		ST_RB,
		ST_LB,
		ST_MUL,
		ST_POST,
		ST_DS,
		ST_DW,
		ST_EMIT
	} back_state_t;

	typedef enum logic [1:0] {
		OP_MINOR,
		OP_MINOR_SUB,
		OP_TERM,
		OP_DET
	} mul_op_t;

	typedef struct packed {
		logic done;
		logic sat;
	} div_stat_t;

	// n-th of the indexes 0..3 once excl is left out
	function automatic logic [1:0] skip_pick(input logic [1:0] excl, input logic [1:0] n);
		skip_pick = (n >= excl) ? n + 2'd1 : n;
	endfunction
endpackage
`default_nettype wire

// ----- sv/matrix_inverse_4x4.sv -----
// 4x4 matrix inverse by adjugate, signed fixed point.
// Input channel: element words with element_valid / element_ready, sixteen per
// matrix in row-major order. Output channel: result_valid / result_ready with
// inverse_element, singular, saturated and last, sixteen words per matrix,
// row-major, last high on the sixteenth.
// Loading runs at one word per cycle through a two-word queue, but only while the
// sequencer is in its load state. After the sixteenth word, all cofactors and the
// determinant are formed on one shift-add multiplier: 148 products in all.
// Each result then comes from a restoring divider that forms 3 * ELEMENT_BITS + 4
// + 2 * FRACTION_BITS quotient bits. With the default widths the multiplier loop
// takes most of a matrix's time. A singular matrix skips the divider.
// Reset clears the load position, the queue and the sequencer; a partly loaded
// matrix is dropped. When the receiver stalls the last result is held in the
// output register and the block stops at the next result; input words still
// queue up to the queue depth.
`timescale 1ns / 1ps
`default_nettype none
module matrix_inverse_4x4 #(
	parameter int ELEMENT_BITS  = mi4_pkg::ElementBits,
	parameter int FRACTION_BITS = mi4_pkg::FractionBits
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic [ELEMENT_BITS-1:0] element,
	input  wire logic                    element_valid,
	output logic                         element_ready,
	output logic [ELEMENT_BITS-1:0]      inverse_element,
	output logic                         singular,
	output logic                         saturated,
	output logic                         last,
	output logic                         result_valid,
	input  wire logic                    result_ready
);
	import mi4_pkg::*;

	localparam int WB = ELEMENT_BITS + 4;

	logic          push_valid;
	logic          push_ready;
	logic [WB-1:0] push_word;
	logic          pop_valid;
	logic          pop_ready;
	logic [WB-1:0] pop_word;

	mi4_front #(
		.EB(ELEMENT_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.element      (element),
		.element_valid(element_valid),
		.element_ready(element_ready),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_word    (push_word)
	);

	mi4_queue #(
		.WB(WB)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_word (push_word),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_word  (pop_word)
	);

	mi4_back #(
		.EB(ELEMENT_BITS),
		.FB(FRACTION_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.pop_valid      (pop_valid),
		.pop_ready      (pop_ready),
		.pop_word       (pop_word),
		.inverse_element(inverse_element),
		.singular       (singular),
		.saturated      (saturated),
		.last           (last),
		.result_valid   (result_valid),
		.result_ready   (result_ready)
	);
endmodule
`default_nettype wire

// ----- sv/mi4_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mi4_front #(
	parameter int EB = mi4_pkg::ElementBits
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [EB-1:0] element,
	input  wire logic          element_valid,
	output logic               element_ready,
	output logic               push_valid,
	input  wire logic          push_ready,
	output logic [EB+3:0]      push_word
);
	import mi4_pkg::*;

	logic [3:0] count_q;

	assign push_valid    = element_valid;
	assign element_ready = push_ready;
	assign push_word     = {element, count_q};

	// tag each word with its place in the matrix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 4'd0;
		end else if (element_valid && push_ready) begin
			count_q <= count_q + 4'd1;
		end
	end
endmodule
`default_nettype wire

// ----- sv/mi4_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mi4_queue #(
	parameter int WB = mi4_pkg::ElementBits + 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	output logic               push_ready,
	input  wire logic [WB-1:0] push_word,
	output logic               pop_valid,
	input  wire logic          pop_ready,
	output logic [WB-1:0]      pop_word
);
	import mi4_pkg::*;

	logic [WB-1:0] slot_q [2];
	logic          wptr_q;
	logic          rptr_q;
	logic [1:0]    fill_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign pop_word   = slot_q[rptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (do_push) begin
				wptr_q <= ~wptr_q;
			end
			if (do_pop) begin
				rptr_q <= ~rptr_q;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end
endmodule
`default_nettype wire

// ----- sv/mi4_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mi4_div #(
	parameter int EB = mi4_pkg::ElementBits,
	parameter int FB = mi4_pkg::FractionBits,
	parameter int CW = 3 * EB + 4,
	parameter int DW = 4 * EB + 6
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [CW-1:0]         num,
	input  wire logic [DW-1:0]         den,
	output mi4_pkg::div_stat_t         stat,
	output logic [EB-1:0]              value
);
	import mi4_pkg::*;

	localparam int NW = CW + 2 * FB;
	localparam int CB = $clog2(NW);

	logic [NW-1:0] n_q;
	logic [NW-1:0] q_q;
	logic [DW-1:0] d_q;
	logic [DW-1:0] r_q;
	logic          neg_q;
	logic [CB-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [CW-1:0] nmag;
	logic [DW-1:0] dmag;
	logic [DW:0]   rs;
	logic          fits;
	logic          big;
	logic          negr;
	logic [EB-1:0] mag;
	logic [EB-1:0] lim;
	logic          sat;
	logic [EB-1:0] mclip;

	assign nmag = num[CW-1] ? (~num + CW'(1)) : num;
	assign dmag = den[DW-1] ? (~den + DW'(1)) : den;
	assign rs   = {r_q, n_q[NW-1]};
	assign fits = (rs >= {1'b0, d_q});

	// restoring divide, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= {nmag, {(2 * FB){1'b0}}};
			d_q   <= dmag;
			r_q   <= '0;
			q_q   <= '0;
			neg_q <= num[CW-1] ^ den[DW-1];
		end else if (busy_q) begin
			n_q <= {n_q[NW-2:0], 1'b0};
			q_q <= {q_q[NW-2:0], fits};
			r_q <= fits ? DW'(rs - {1'b0, d_q}) : DW'(rs);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CB'(1);
				if (cnt_q == CB'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign big   = |q_q[NW-1:EB];
	assign mag   = q_q[EB-1:0];
	assign negr  = neg_q && (q_q != '0);
	assign lim   = negr ? {1'b1, {(EB-1){1'b0}}} : {1'b0, {(EB-1){1'b1}}};
	assign sat   = big || (mag > lim);
	assign mclip = sat ? lim : mag;
	assign value = negr ? (~mclip + EB'(1)) : mclip;

	assign stat.done = done_q;
	assign stat.sat  = sat;
endmodule
`default_nettype wire

// ----- sv/mi4_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mi4_back #(
	parameter int EB = mi4_pkg::ElementBits,
	parameter int FB = mi4_pkg::FractionBits
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          pop_valid,
	output logic               pop_ready,
	input  wire logic [EB+3:0] pop_word,
	output logic [EB-1:0]      inverse_element,
	output logic               singular,
	output logic               saturated,
	output logic               last,
	output logic               result_valid,
	input  wire logic          result_ready
);
	import mi4_pkg::*;

	localparam int CW = 3 * EB + 4;
	localparam int DW = 4 * EB + 6;
	localparam int BB = $clog2(EB);

	back_state_t   state_q;
	back_state_t   state_d;
	mul_op_t       op_q;
	logic [3:0]    cof_idx_q;
	logic [1:0]    term_q;
	logic [3:0]    out_idx_q;
	logic [BB-1:0] bit_q;

	logic [EB-1:0] mem_q [16];
	logic [EB-1:0] rdata_q;
	logic [3:0]    raddr;

	logic [DW-1:0] opa_q;
	logic [EB-1:0] opb_q;
	logic [DW-1:0] prod_q;
	logic [DW-1:0] minor_q;
	logic [DW-1:0] acc_q;
	logic [DW-1:0] det_q;
	logic [CW-1:0] cof_q [16];

	logic [1:0]    row_r;
	logic [1:0]    col_c;
	logic [1:0]    k0;
	logic [1:0]    k1;
	logic [1:0]    k2;
	logic [1:0]    lt;
	logic [1:0]    cu;
	logic [1:0]    cv;
	logic [3:0]    addr_a;
	logic [3:0]    addr_b;
	logic [DW-1:0] addend;
	logic          tsign;
	logic [DW-1:0] acc_next;
	logic          term_done;
	logic          cof_done;
	logic          det_zero;
	logic          out_free;
	logic          div_start;
	div_stat_t     dstat;
	logic [EB-1:0] dvalue;
	logic [3:0]    cof_rd;

	assign row_r = cof_idx_q[3:2];
	assign col_c = cof_idx_q[1:0];
	assign k0    = skip_pick(row_r, 2'd0);
	assign k1    = skip_pick(row_r, 2'd1);
	assign k2    = skip_pick(row_r, 2'd2);
	assign lt    = skip_pick(col_c, term_q);
	assign cu    = skip_pick(col_c, (term_q == 2'd0) ? 2'd1 : 2'd0);
	assign cv    = skip_pick(col_c, (term_q == 2'd2) ? 2'd1 : 2'd2);

	always_comb begin
		case (op_q)
			OP_MINOR: begin
				addr_a = {k1, cu};
				addr_b = {k2, cv};
			end
			OP_MINOR_SUB: begin
				addr_a = {k1, cv};
				addr_b = {k2, cu};
			end
			OP_TERM: begin
				addr_a = {k0, lt};
				addr_b = {k0, lt};
			end
			default: begin
				addr_a = {2'd0, col_c};
				addr_b = {2'd0, col_c};
			end
		endcase
	end

	assign raddr     = (state_q == ST_RB) ? addr_b : addr_a;
	assign addend    = opb_q[bit_q] ? opa_q : '0;
	assign tsign     = (term_q == 2'd1) ^ row_r[0] ^ col_c[0];
	assign acc_next  = tsign ? (acc_q - prod_q) : (acc_q + prod_q);
	assign term_done = (op_q == OP_TERM) && (term_q == 2'd2);
	assign cof_done  = (op_q == OP_DET) || (term_done && (row_r != 2'd0));
	assign det_zero  = (det_q == '0);
	assign out_free  = !result_valid || result_ready;
	assign div_start = (state_q == ST_DS) && !det_zero;
	assign cof_rd    = {out_idx_q[1:0], out_idx_q[3:2]};
	assign pop_ready = (state_q == ST_LOAD);

	mi4_div #(
		.EB(EB),
		.FB(FB),
		.CW(CW),
		.DW(DW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (cof_q[cof_rd]),
		.den   (det_q),
		.stat  (dstat),
		.value (dvalue)
	);

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			mem_q[pop_word[3:0]] <= pop_word[EB+3:4];
		end
		rdata_q <= mem_q[raddr];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (pop_valid && (pop_word[3:0] == 4'd15)) begin
					state_d = ST_RA;
				end
			end
			ST_RA: state_d = ST_RB;
			ST_RB: state_d = ST_LB;
			ST_LB: state_d = ST_MUL;
			ST_MUL: begin
				if (bit_q == BB'(EB - 1)) begin
					state_d = ST_POST;
				end
			end
			ST_POST: begin
				state_d = (cof_done && (cof_idx_q == 4'd15)) ? ST_DS : ST_RA;
			end
			ST_DS: state_d = det_zero ? ST_EMIT : ST_DW;
			ST_DW: begin
				if (dstat.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = (out_idx_q == 4'd15) ? ST_LOAD : ST_DS;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath: shared shift-add multiplier, cofactor and determinant sums
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				cof_idx_q <= 4'd0;
				term_q    <= 2'd0;
				op_q      <= OP_MINOR;
				acc_q     <= '0;
				det_q     <= '0;
			end
			ST_RB: begin
				case (op_q)
					OP_TERM: opa_q <= minor_q;
					OP_DET:  opa_q <= acc_q;
					default: opa_q <= {{(DW-EB){rdata_q[EB-1]}}, rdata_q};
				endcase
			end
			ST_LB: begin
				opb_q  <= rdata_q;
				prod_q <= '0;
				bit_q  <= '0;
			end
			ST_MUL: begin
				prod_q <= (bit_q == BB'(EB - 1)) ? (prod_q - addend) : (prod_q + addend);
				opa_q  <= {opa_q[DW-2:0], 1'b0};
				bit_q  <= bit_q + BB'(1);
			end
			ST_POST: begin
				case (op_q)
					OP_MINOR: begin
						minor_q <= prod_q;
						op_q    <= OP_MINOR_SUB;
					end
					OP_MINOR_SUB: begin
						minor_q <= minor_q - prod_q;
						op_q    <= OP_TERM;
					end
					OP_TERM: begin
						acc_q <= acc_next;
						if (term_q != 2'd2) begin
							term_q <= term_q + 2'd1;
							op_q   <= OP_MINOR;
						end else begin
							cof_q[cof_idx_q] <= acc_next[CW-1:0];
							if (row_r == 2'd0) begin
								op_q <= OP_DET;
							end else begin
								cof_idx_q <= cof_idx_q + 4'd1;
								term_q    <= 2'd0;
								op_q      <= OP_MINOR;
								acc_q     <= '0;
							end
						end
					end
					default: begin
						det_q     <= det_q + prod_q;
						cof_idx_q <= cof_idx_q + 4'd1;
						term_q    <= 2'd0;
						op_q      <= OP_MINOR;
						acc_q     <= '0;
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && out_free) begin
			inverse_element <= det_zero ? '0 : dvalue;
			singular        <= det_zero;
			saturated       <= !det_zero && dstat.sat;
			last            <= (out_idx_q == 4'd15);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
			out_idx_q    <= 4'd0;
		end else begin
			if ((state_q == ST_EMIT) && out_free) begin
				result_valid <= 1'b1;
				out_idx_q    <= out_idx_q + 4'd1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire
